// ===== rtl/fsv_pkg.sv =====
`default_nettype none

package fsv_pkg;

	localparam int CHAR_W = 8;

	// field positions within the record
	localparam logic [2:0] FLD_BOARD   = 3'd0;
	localparam logic [2:0] FLD_COLOR   = 3'd1;
	localparam logic [2:0] FLD_CASTLE  = 3'd2;
	localparam logic [2:0] FLD_PASSANT = 3'd3;
	localparam logic [2:0] FLD_HALF    = 3'd4;
	localparam logic [2:0] FLD_FULL    = 3'd5;
	localparam logic [2:0] FLD_DONE    = 3'd6;

	// move number scan phases
	localparam logic [1:0] NUM_LEAD  = 2'd0;
	localparam logic [1:0] NUM_SIGN  = 2'd1;
	localparam logic [1:0] NUM_DIGIT = 2'd2;

	localparam logic [3:0] RANKS_PER_BOARD = 4'd8;
	localparam logic [3:0] CELLS_PER_RANK  = 4'd8;
	localparam logic [3:0] COUNT_SAT       = 4'd9;
	localparam logic [1:0] TOKEN_LEN_SAT   = 2'd3;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
	localparam logic [CHAR_W-1:0] CH_SIX   = 8'h36;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_B  = 8'h42;
	localparam logic [CHAR_W-1:0] CH_UP_K  = 8'h4b;
	localparam logic [CHAR_W-1:0] CH_UP_N  = 8'h4e;
	localparam logic [CHAR_W-1:0] CH_UP_P  = 8'h50;
	localparam logic [CHAR_W-1:0] CH_UP_Q  = 8'h51;
	localparam logic [CHAR_W-1:0] CH_UP_R  = 8'h52;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;
	localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
	localparam logic [CHAR_W-1:0] CH_LO_K  = 8'h6b;
	localparam logic [CHAR_W-1:0] CH_LO_N  = 8'h6e;
	localparam logic [CHAR_W-1:0] CH_LO_P  = 8'h70;
	localparam logic [CHAR_W-1:0] CH_LO_Q  = 8'h71;
	localparam logic [CHAR_W-1:0] CH_LO_R  = 8'h72;
	localparam logic [CHAR_W-1:0] CH_LO_W  = 8'h77;

	function automatic logic is_piece(input logic [CHAR_W-1:0] c);
		logic hit;
		hit = 1'b0;
		case (c)
			CH_LO_P, CH_LO_R, CH_LO_N, CH_LO_B, CH_LO_Q, CH_LO_K,
			CH_UP_P, CH_UP_R, CH_UP_N, CH_UP_B, CH_UP_Q, CH_UP_K: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// one-hot slot of a castling letter, zero for anything else
	function automatic logic [3:0] castle_bit(input logic [CHAR_W-1:0] c);
		logic [3:0] b;
		b = 4'b0000;
		case (c)
			CH_UP_K: b = 4'b0001;
			CH_UP_Q: b = 4'b0010;
			CH_LO_K: b = 4'b0100;
			CH_LO_Q: b = 4'b1000;
			default: b = 4'b0000;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fsv_if.sv =====
`default_nettype none

interface fsv_char_if;
	logic                       valid;
	logic                       ready;
	logic [fsv_pkg::CHAR_W-1:0] char_code;
	logic                       end_of_string;

	modport source (output valid, output char_code, output end_of_string, input ready);
	modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface fsv_verdict_if;
	logic valid;
	logic ready;
	logic fen_valid;

	modport source (output valid, output fen_valid, input ready);
	modport sink   (input valid, input fen_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/fsv_parser.sv =====
`default_nettype none

module fsv_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [fsv_pkg::CHAR_W-1:0] char_code,
	input  wire logic                       end_of_string,
	output logic                            verdict
);
	import fsv_pkg::*;

	typedef struct packed {
		logic [2:0] fld;
		logic       in_tok;
		logic [1:0] tok_len;
		logic       dash;
		logic [3:0] ranks;
		logic [3:0] cells;
		logic       rank_open;
		logic [3:0] castle;
		logic [1:0] phase;
		logic       neg;
		logic       nz;
		logic       err;
	} parse_state_t;

	localparam parse_state_t ST_RESET = '0;

	parse_state_t st_q;
	parse_state_t st_d;
	parse_state_t ended;
	logic [1:0]   pos;
	logic         is_dig;
	logic [3:0]   add;
	logic [4:0]   sum;
	logic [3:0]   cbit;

	// error raised by closing the current field
	function automatic logic close_err(input parse_state_t s);
		logic e;
		e = 1'b0;
		case (s.fld)
			FLD_BOARD:   e = (s.rank_open && s.cells != CELLS_PER_RANK) ||
				(s.ranks != RANKS_PER_BOARD);
			FLD_PASSANT: e = (s.tok_len == 2'd1) && !s.dash;
			FLD_HALF:    e = (s.phase != NUM_DIGIT) || (s.neg && s.nz);
			FLD_FULL:    e = (s.phase != NUM_DIGIT) || s.neg || !s.nz;
			default:     e = 1'b0;
		endcase
		return e;
	endfunction

	// close the last field if open, otherwise the record is short
	function automatic parse_state_t string_end(input parse_state_t s);
		parse_state_t r;
		r = s;
		if (s.fld < FLD_DONE) begin
			if (s.fld == FLD_FULL && s.in_tok) begin
				r.err = s.err | close_err(s);
			end else begin
				r.err = 1'b1;
			end
			r.fld    = FLD_DONE;
			r.in_tok = 1'b0;
		end
		return r;
	endfunction

	assign is_dig = char_code inside {[CH_ZERO:CH_NINE]};
	assign cbit   = castle_bit(char_code);
	assign ended  = string_end(st_q);
	assign verdict = !ended.err;

	always_comb begin
		st_d = st_q;
		pos  = 2'd0;
		add  = 4'd0;
		sum  = 5'd0;
		if (end_of_string) begin
			st_d = ST_RESET;
		end else if (st_q.fld >= FLD_DONE) begin
			st_d = st_q;
		end else if (char_code == CH_NUL) begin
			st_d = ended;
		end else if (char_code == CH_SPACE) begin
			if (st_q.in_tok) begin
				st_d.err    = st_q.err | close_err(st_q);
				st_d.in_tok = 1'b0;
				st_d.fld    = st_q.fld + 3'd1;
			end
		end else begin
			if (!st_q.in_tok) begin
				st_d.in_tok    = 1'b1;
				st_d.tok_len   = 2'd0;
				st_d.dash      = 1'b0;
				st_d.ranks     = 4'd0;
				st_d.cells     = 4'd0;
				st_d.rank_open = 1'b0;
				st_d.castle    = 4'b0000;
				st_d.phase     = NUM_LEAD;
				st_d.neg       = 1'b0;
				st_d.nz        = 1'b0;
			end
			pos = st_d.tok_len;
			if (st_d.tok_len != TOKEN_LEN_SAT) begin
				st_d.tok_len = st_d.tok_len + 2'd1;
			end
			case (st_d.fld)
				FLD_BOARD: begin
					if (char_code == CH_SLASH) begin
						if (st_d.rank_open && st_d.cells != CELLS_PER_RANK) begin
							st_d.err = 1'b1;
						end
						st_d.rank_open = 1'b0;
					end else if (is_dig || is_piece(char_code)) begin
						add = is_dig ? char_code[3:0] : 4'd1;
						if (!st_d.rank_open) begin
							st_d.rank_open = 1'b1;
							st_d.cells     = 4'd0;
							if (st_d.ranks < COUNT_SAT) begin
								st_d.ranks = st_d.ranks + 4'd1;
							end
						end
						sum = {1'b0, st_d.cells} + {1'b0, add};
						st_d.cells = (sum > {1'b0, COUNT_SAT}) ? COUNT_SAT : sum[3:0];
					end else begin
						st_d.err = 1'b1;
					end
				end
				FLD_COLOR: begin
					if (pos != 2'd0 || !(char_code == CH_LO_W || char_code == CH_LO_B)) begin
						st_d.err = 1'b1;
					end
				end
				FLD_CASTLE: begin
					if (pos == 2'd0 && char_code == CH_DASH) begin
						st_d.dash = 1'b1;
					end else if (st_d.dash || cbit == 4'b0000) begin
						st_d.err = 1'b1;
					end else begin
						if ((st_d.castle & cbit) != 4'b0000) begin
							st_d.err = 1'b1;
						end
						st_d.castle = st_d.castle | cbit;
					end
				end
				FLD_PASSANT: begin
					if (pos == 2'd0) begin
						if (char_code == CH_DASH) begin
							st_d.dash = 1'b1;
						end else if (!(char_code inside {[CH_LO_A:CH_LO_H]})) begin
							st_d.err = 1'b1;
						end
					end else if (pos == 2'd1) begin
						if (st_d.dash || !(char_code == CH_THREE || char_code == CH_SIX)) begin
							st_d.err = 1'b1;
						end
					end else begin
						st_d.err = 1'b1;
					end
				end
				default: begin
					if (st_d.phase == NUM_LEAD && (char_code inside {[CH_TAB:CH_CR]})) begin
						st_d.phase = NUM_LEAD;
					end else if (st_d.phase == NUM_LEAD &&
						(char_code == CH_PLUS || char_code == CH_DASH)) begin
						st_d.neg   = st_d.neg | (char_code == CH_DASH);
						st_d.phase = NUM_SIGN;
					end else if (is_dig) begin
						st_d.phase = NUM_DIGIT;
						if (char_code != CH_ZERO) begin
							st_d.nz = 1'b1;
						end
					end else begin
						st_d.err = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (step) begin
			st_q <= st_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fen_string_validator.sv =====
`default_nettype none

// Checks a FEN record streamed one byte per item on chars; an item with
// end_of_string set returns one verdict item on verdict (fen_valid = 1 when the
// record is well formed) and clears the parser for the next record. The block
// accepts an item on every clock edge unless stalled as below; each item
// passes an input register and then updates the parser state register, and
// the verdict appears from an output register once the terminator leaves the
// input register. Only a terminator can stall the input, and only while the
// previous verdict is still waiting to be taken.
module fen_string_validator (
	input wire logic      clk,
	input wire logic      arst_n,
	fsv_char_if.sink      chars,
	fsv_verdict_if.source verdict
);
	import fsv_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eos_s1;
	logic              out_valid_q;
	logic              fen_valid_q;
	logic              advance;
	logic              parse_ok;

	// a terminator moves on only when the output slot is free
	assign advance      = valid_s1 && (!eos_s1 || !out_valid_q || verdict.ready);
	assign chars.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			eos_s1  <= chars.end_of_string;
		end
	end

	fsv_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.char_code     (char_s1),
		.end_of_string (eos_s1),
		.verdict       (parse_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eos_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eos_s1) begin
			fen_valid_q <= parse_ok;
		end
	end

	assign verdict.valid     = out_valid_q;
	assign verdict.fen_valid = fen_valid_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && eos_s1 && out_valid_q && !verdict.ready) |=>
		(valid_s1 && eos_s1 && out_valid_q))
		else $error("stalled terminator lost from input stage");

	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && eos_s1))
		else $error("verdict raised without a terminator");

	a_ready_only_stalls_full: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> (valid_s1 && eos_s1 && out_valid_q))
		else $error("input stalled without a pending verdict");

	a_bytes_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !eos_s1 && !out_valid_q) |=> !out_valid_q)
		else $error("plain byte produced a verdict");

endmodule

`default_nettype wire
